/* rtl/core/spsub_pkg.sv */
`default_nettype none

package spsub_pkg;

  // Field widths of one term
  localparam int unsigned CoefW = 32;
  localparam int unsigned ExpW  = 10;

  // Most results that one run may emit
  localparam int unsigned MaxResults = 32;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);

  // Saturation bounds of a Q16.16 coefficient
  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  // One stored term
  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic [ExpW-1:0]         exponent;
  } term_t;

  // Subtract two coefficients and clamp to the coefficient range
  function automatic logic signed [CoefW-1:0] sat_sub(
    input logic signed [CoefW-1:0] lhs,
    input logic signed [CoefW-1:0] rhs
  );
    logic signed [CoefW:0] wide;
    wide = {lhs[CoefW-1], lhs} - {rhs[CoefW-1], rhs};
    if (wide[CoefW] != wide[CoefW-1]) begin
      sat_sub = wide[CoefW] ? CoefMin : CoefMax;
    end else begin
      sat_sub = wide[CoefW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sparse_polynomial_subtract.sv */
// Load and clear items are taken while idle and emit nothing.
// A run item consumes one head term, or one pair of equal exponents, per cycle
// while the output is free; the input stays stalled for those steps and for
// the closing step that emits the last result of the run.
// Results follow at up to one per cycle while the output is not stalled.
// Reset empties both stores and clears the overflow flag; no clearing pass.
`default_nettype none

module sparse_polynomial_subtract #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic signed [spsub_pkg::CoefW-1:0] term_coef_i,
  input  wire logic [spsub_pkg::ExpW-1:0]         term_exponent_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic signed [spsub_pkg::CoefW-1:0] diff_coef_o,
  output      logic [spsub_pkg::ExpW-1:0]         diff_exponent_o,
  output      logic                               last_term_o,
  output      logic                               empty_result_o,
  output      logic                               overflow_seen_o
);
  import spsub_pkg::*;

  localparam int unsigned IdxW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned Depth = 1 << IdxW;
  localparam int unsigned CntW  = $clog2(MAX_TERMS + 1);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [CntW-1:0]         ia_q, ia_d, ib_q, ib_d;
  logic [NumW-1:0]         num_q, num_d;
  logic                    ovf_q, ovf_d;
  logic signed [CoefW-1:0] hold_coef_q, hold_coef_d;
  logic [ExpW-1:0]         hold_exp_q, hold_exp_d;
  logic                    out_vld_q, out_vld_d;
  logic signed [CoefW-1:0] out_coef_q, out_coef_d;
  logic [ExpW-1:0]         out_exp_q, out_exp_d;
  logic                    out_last_q, out_last_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_ovf_q, out_ovf_d;

  logic                    a_we, b_we;
  term_t                   wr_term, a_rd, b_rd;
  logic                    out_free, a_ok, b_ok, more, take_a, take_b, produce;
  logic signed [CoefW-1:0] new_coef;
  logic [ExpW-1:0]         new_exp;

  assign wr_term = {term_coef_i, term_exponent_i};

  // Term stores, read at the next merge heads
  spsub_store #(.Depth(Depth), .IdxW(IdxW)) u_store_a (
    .clk_i     (clk_i),
    .wr_en_i   (a_we),
    .wr_addr_i (a_cnt_q[IdxW-1:0]),
    .wr_data_i (wr_term),
    .rd_addr_i (ia_d[IdxW-1:0]),
    .rd_data_o (a_rd)
  );

  spsub_store #(.Depth(Depth), .IdxW(IdxW)) u_store_b (
    .clk_i     (clk_i),
    .wr_en_i   (b_we),
    .wr_addr_i (b_cnt_q[IdxW-1:0]),
    .wr_data_i (wr_term),
    .rd_addr_i (ib_d[IdxW-1:0]),
    .rd_data_o (b_rd)
  );

  // Pick the head term of the merge and its coefficient
  always_comb begin
    a_ok = ia_q < a_cnt_q;
    b_ok = ib_q < b_cnt_q;
    more = (a_ok || b_ok) && (num_q < NumW'(MaxResults));
    if (a_ok && b_ok) begin
      take_a = a_rd.exponent >= b_rd.exponent;
      take_b = b_rd.exponent >= a_rd.exponent;
    end else begin
      take_a = a_ok;
      take_b = !a_ok;
    end
    if (take_a && take_b) begin
      new_coef = sat_sub(a_rd.coef, b_rd.coef);
      new_exp  = a_rd.exponent;
      produce  = new_coef != '0;
    end else if (take_a) begin
      new_coef = a_rd.coef;
      new_exp  = a_rd.exponent;
      produce  = 1'b1;
    end else begin
      new_coef = sat_sub('0, b_rd.coef);
      new_exp  = b_rd.exponent;
      produce  = 1'b1;
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;

  // Next state: loads, clear and run start in idle, one merge step per cycle in a run while the output is free
  always_comb begin
    state_d     = state_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    num_d       = num_q;
    ovf_d       = ovf_q;
    hold_coef_d = hold_coef_q;
    hold_exp_d  = hold_exp_q;
    out_vld_d   = out_vld_q;
    out_coef_d  = out_coef_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    a_we        = 1'b0;
    b_we        = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        ia_d  = '0;
        ib_d  = '0;
        num_d = '0;
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_LOAD_A: begin
              if (a_cnt_q >= CntW'(MAX_TERMS)) begin
                ovf_d = 1'b1;
              end else begin
                a_we    = 1'b1;
                a_cnt_d = a_cnt_q + CntW'(1);
              end
            end
            OP_LOAD_B: begin
              if (b_cnt_q >= CntW'(MAX_TERMS)) begin
                ovf_d = 1'b1;
              end else begin
                b_we    = 1'b1;
                b_cnt_d = b_cnt_q + CntW'(1);
              end
            end
            OP_RUN: begin
              state_d = ST_MERGE;
            end
            OP_CLEAR: begin
              a_cnt_d = '0;
              b_cnt_d = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          if (more) begin
            // Advance the heads; push the held term out when a new one arrives
            ia_d = ia_q + CntW'(take_a);
            ib_d = ib_q + CntW'(take_b);
            if (produce) begin
              if (num_q != '0) begin
                out_vld_d   = 1'b1;
                out_coef_d  = hold_coef_q;
                out_exp_d   = hold_exp_q;
                out_last_d  = 1'b0;
                out_empty_d = 1'b0;
                out_ovf_d   = ovf_q;
              end
              hold_coef_d = new_coef;
              hold_exp_d  = new_exp;
              num_d       = num_q + NumW'(1);
            end
          end else begin
            // Close the run with the held term, or an empty marker
            out_vld_d   = 1'b1;
            out_last_d  = 1'b1;
            out_ovf_d   = ovf_q;
            if (num_q != '0) begin
              out_coef_d  = hold_coef_q;
              out_exp_d   = hold_exp_q;
              out_empty_d = 1'b0;
            end else begin
              out_coef_d  = '0;
              out_exp_d   = '0;
              out_empty_d = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, counters and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      num_q       <= '0;
      ovf_q       <= 1'b0;
      hold_coef_q <= '0;
      hold_exp_q  <= '0;
      out_vld_q   <= 1'b0;
      out_coef_q  <= '0;
      out_exp_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      num_q       <= num_d;
      ovf_q       <= ovf_d;
      hold_coef_q <= hold_coef_d;
      hold_exp_q  <= hold_exp_d;
      out_vld_q   <= out_vld_d;
      out_coef_q  <= out_coef_d;
      out_exp_q   <= out_exp_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign diff_coef_o     = out_coef_q;
  assign diff_exponent_o = out_exp_q;
  assign last_term_o     = out_last_q;
  assign empty_result_o  = out_empty_q;
  assign overflow_seen_o = out_ovf_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_cnt_q <= CntW'(MAX_TERMS)) && (b_cnt_q <= CntW'(MAX_TERMS)))
    else $error("store count beyond capacity");

  head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ia_q <= a_cnt_q) && (ib_q <= b_cnt_q))
    else $error("merge head passed the store count");

  ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ovf_q))
    else $error("overflow flag cleared");

  counts_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |=> ($stable(a_cnt_q) && $stable(b_cnt_q)))
    else $error("store count changed during a run");

  empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_empty_q) |-> (out_last_q && (out_coef_q == '0)))
    else $error("empty marker not a zero last item");
`endif

endmodule

`default_nettype wire

/* rtl/core/spsub_store.sv */
`default_nettype none

module spsub_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [IdxW-1:0]     wr_addr_i,
  input  wire spsub_pkg::term_t    wr_data_i,
  input  wire logic [IdxW-1:0]     rd_addr_i,
  output spsub_pkg::term_t         rd_data_o
);
  import spsub_pkg::*;

  term_t mem [Depth];
  term_t rd_data_q;

  // Write one term
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* verif/spsub_tb_pkg.sv */
`timescale 1ns / 100ps

package spsub_tb_pkg;

  // Item opcodes of the subtractor input channel
  typedef enum logic [1:0] {
    OpLoadA = 2'd0,
    OpLoadB = 2'd1,
    OpRun   = 2'd2,
    OpClear = 2'd3
  } spsub_op_e;

endpackage

/* verif/spsub_checker.sv */
`timescale 1ns / 100ps

module spsub_checker #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         opcode_i,
  input  logic signed [spsub_pkg::CoefW-1:0] term_coef_i,
  input  logic [spsub_pkg::ExpW-1:0]         term_exponent_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [spsub_pkg::CoefW-1:0] diff_coef_i,
  input  logic [spsub_pkg::ExpW-1:0]         diff_exponent_i,
  input  logic                               last_term_i,
  input  logic                               empty_result_i,
  input  logic                               overflow_seen_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import spsub_pkg::*;
  import spsub_tb_pkg::*;

  localparam int unsigned PrintLimit = 40;

  // One predicted difference term
  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic [ExpW-1:0]         exponent;
    logic                    last;
    logic                    empty;
    logic                    overflow;
  } diff_term_t;

  // Shadow copy of both term stores
  term_t       a_store [MAX_TERMS];
  term_t       b_store [MAX_TERMS];
  int unsigned a_used;
  int unsigned b_used;
  logic        overflow_flag;

  diff_term_t  diff_terms_due [$];
  int          mismatches;

  assign fail_count_o = mismatches;

  // Print one line per mismatch, up to a limit, and count every one
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PrintLimit) begin
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Clamp a wide value to the Q16.16 coefficient range
  function automatic logic signed [CoefW-1:0] clamp_coef(longint value);
    if (value > longint'(32'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (value < -longint'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return value[CoefW-1:0];
  endfunction

  // Append one term to a store, or drop it and flag overflow when full
  task automatic store_term(inout term_t store [MAX_TERMS], inout int unsigned used);
    if (used >= MAX_TERMS) begin
      overflow_flag = 1'b1;
    end else begin
      store[used].coef     = term_coef_i;
      store[used].exponent = term_exponent_i;
      used++;
    end
  endtask

  // Merge both stores by exponent and queue the terms of A minus B
  task automatic predict_difference();
    diff_term_t  run_terms [MaxResults];
    int unsigned ia;
    int unsigned ib;
    int unsigned n;
    logic        take_a;
    logic        take_b;
    longint      wide;
    ia = 0;
    ib = 0;
    n  = 0;
    while ((ia < a_used || ib < b_used) && n < MaxResults) begin
      if (ia < a_used && ib < b_used) begin
        take_a = a_store[ia].exponent >= b_store[ib].exponent;
        take_b = b_store[ib].exponent >= a_store[ia].exponent;
      end else begin
        take_a = ia < a_used;
        take_b = !take_a;
      end
      if (take_a && take_b) begin
        // equal exponents: drop the term when the difference cancels
        wide = longint'(a_store[ia].coef) - longint'(b_store[ib].coef);
        if (wide != 0) begin
          run_terms[n] = '{clamp_coef(wide), a_store[ia].exponent, 1'b0, 1'b0, overflow_flag};
          n++;
        end
        ia++;
        ib++;
      end else if (take_a) begin
        run_terms[n] = '{a_store[ia].coef, a_store[ia].exponent, 1'b0, 1'b0, overflow_flag};
        n++;
        ia++;
      end else begin
        wide = -longint'(b_store[ib].coef);
        run_terms[n] = '{clamp_coef(wide), b_store[ib].exponent, 1'b0, 1'b0, overflow_flag};
        n++;
        ib++;
      end
    end
    if (n == 0) begin
      run_terms[0] = '{'0, '0, 1'b0, 1'b1, overflow_flag};
      n = 1;
    end
    run_terms[n-1].last = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      diff_terms_due.push_back(run_terms[k]);
    end
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    diff_term_t want;
    if (diff_terms_due.size() == 0) begin
      report_mismatch("result with nothing due", diff_coef_i, '0);
    end else begin
      want = diff_terms_due.pop_front();
      if (diff_coef_i !== want.coef) begin
        report_mismatch("diff_coef", diff_coef_i, want.coef);
      end
      if (diff_exponent_i !== want.exponent) begin
        report_mismatch("diff_exponent", 32'(diff_exponent_i), 32'(want.exponent));
      end
      if (last_term_i !== want.last) begin
        report_mismatch("last_term", 32'(last_term_i), 32'(want.last));
      end
      if (empty_result_i !== want.empty) begin
        report_mismatch("empty_result", 32'(empty_result_i), 32'(want.empty));
      end
      if (overflow_seen_i !== want.overflow) begin
        report_mismatch("overflow_seen", 32'(overflow_seen_i), 32'(want.overflow));
      end
    end
  endtask

  // Track accepted items and results on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_used        = 0;
      b_used        = 0;
      overflow_flag = 1'b0;
      mismatches    = 0;
      diff_terms_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (opcode_i)
          OpLoadA: store_term(a_store, a_used);
          OpLoadB: store_term(b_store, b_used);
          OpRun:   predict_difference();
          default: begin
            a_used = 0;
            b_used = 0;
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
    end
    pending_o = diff_terms_due.size();
  end

endmodule

/* verif/sparse_polynomial_subtract_tb.sv */
`timescale 1ns / 100ps

module sparse_polynomial_subtract_tb;

  import spsub_pkg::*;
  import spsub_tb_pkg::*;

  localparam int unsigned MaxTerms    = 16;
  localparam int unsigned RandomItems = 60;
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned DrainCycles = 60;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic [1:0]              opcode        = OpClear;
  logic signed [CoefW-1:0] term_coef     = '0;
  logic [ExpW-1:0]         term_exponent = '0;
  logic                    out_stall     = 1'b0;
  wire                     in_stall;
  wire                     out_valid;
  wire signed [CoefW-1:0]  diff_coef;
  wire [ExpW-1:0]          diff_exponent;
  wire                     last_term;
  wire                     empty_result;
  wire                     overflow_seen;

  int unsigned send_idle_pct  = 18;
  int unsigned recv_idle_pct  = 47;
  logic        stall_hold_req = 1'b0;
  int unsigned items_sent     = 0;
  int          fail_count;
  int          pending;

  sparse_polynomial_subtract #(
    .MAX_TERMS(MaxTerms)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .term_coef_i    (term_coef),
    .term_exponent_i(term_exponent),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .diff_coef_o    (diff_coef),
    .diff_exponent_o(diff_exponent),
    .last_term_o    (last_term),
    .empty_result_o (empty_result),
    .overflow_seen_o(overflow_seen)
  );

  spsub_checker #(
    .MAX_TERMS(MaxTerms)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .term_coef_i    (term_coef),
    .term_exponent_i(term_exponent),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .diff_coef_i    (diff_coef),
    .diff_exponent_i(diff_exponent),
    .last_term_i    (last_term),
    .empty_result_i (empty_result),
    .overflow_seen_i(overflow_seen),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the result channel at random; hold it off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_hold_req) begin
        stall_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item after a random gap and wait until it is taken
  task automatic send_item(spsub_op_e op, logic [CoefW-1:0] coef, logic [ExpW-1:0] expo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    term_coef     <= coef;
    term_exponent <= expo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering items until every predicted result has come out
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pick a coefficient, leaning on the saturation corners
  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return CoefMax;
      1:       return CoefMin;
      2:       return '0;
      3:       return -1;
      4:       return $urandom_range(255) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Load two descending polynomials with shared exponents, then run
  task automatic send_pair(int unsigned na, int unsigned nb);
    logic [CoefW-1:0] a_coef_at [1024];
    bit               a_has [1024];
    int               hi;
    int               cur;
    logic [CoefW-1:0] coef;
    hi  = ($urandom_range(3) == 0) ? 1023 : $urandom_range(1023, 60);
    cur = hi;
    for (int unsigned i = 0; i < na; i++) begin
      coef = pick_coef();
      a_coef_at[cur] = coef;
      a_has[cur]     = 1'b1;
      send_item(OpLoadA, coef, cur[ExpW-1:0]);
      cur -= $urandom_range(3, 1);
      if (cur < 0) cur = 0;
    end
    cur = hi - $urandom_range(1, 0);
    for (int unsigned i = 0; i < nb; i++) begin
      // reuse the A coefficient now and then so that terms cancel
      coef = (a_has[cur] && $urandom_range(2) == 0) ? a_coef_at[cur] : pick_coef();
      send_item(OpLoadB, coef, cur[ExpW-1:0]);
      cur -= $urandom_range(3, 1);
      if (cur < 0) cur = 0;
    end
    send_item(OpRun, $urandom, ExpW'($urandom_range(1023)));
  endtask

  // Pick a polynomial size, mostly small
  function automatic int unsigned pick_size();
    return ($urandom_range(3) == 0) ? $urandom_range(MaxTerms, 8) : $urandom_range(6, 0);
  endfunction

  // Stimulus
  initial begin
    int unsigned base;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty run, saturation corners, cancellation, unordered input
    send_item(OpRun, '0, '0);
    send_item(OpLoadA, CoefMax, 10'd1023);
    send_item(OpLoadA, 32'h1234_5678, 10'd500);
    send_item(OpLoadA, CoefMin, 10'd40);
    send_item(OpLoadA, -1, 10'd3);
    send_item(OpLoadA, '0, 10'd2);
    send_item(OpLoadA, 32'h0000_8000, 10'd900);
    send_item(OpLoadB, CoefMin, 10'd1023);
    send_item(OpLoadB, 32'h1234_5678, 10'd500);
    send_item(OpLoadB, 32'd1, 10'd40);
    send_item(OpLoadB, CoefMin, 10'd0);
    send_item(OpRun, '1, '1);
    send_item(OpRun, '0, '0);
    send_item(OpClear, '1, '1);
    send_item(OpRun, '0, '0);
    send_item(OpLoadA, 32'hABCD_0000, 10'd7);
    send_item(OpLoadB, 32'hABCD_0000, 10'd7);
    send_item(OpRun, '0, '0);
    pause_until_drained();

    // Hold off the receiver while both stores overfill and runs back up
    stall_hold_req = 1'b1;
    send_item(OpClear, $urandom, ExpW'($urandom_range(1023)));
    send_pair(MaxTerms + 1, MaxTerms);
    send_item(OpRun, $urandom, ExpW'($urandom_range(1023)));
    send_item(OpLoadB, pick_coef(), ExpW'($urandom_range(1023)));
    send_item(OpRun, $urandom, ExpW'($urandom_range(1023)));
    pause_until_drained();

    // Random: well-formed runs, overfills and noise over three idling phases
    base = items_sent;
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < base + RandomItems * (phase + 1) / 3) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          send_item(OpClear, $urandom, ExpW'($urandom_range(1023)));
          send_pair(pick_size(), pick_size());
          if ($urandom_range(3) == 0) begin
            send_item(OpRun, $urandom, ExpW'($urandom_range(1023)));
          end
        end else if (pick < 7) begin
          send_item(OpClear, $urandom, ExpW'($urandom_range(1023)));
          send_pair($urandom_range(MaxTerms + 2, MaxTerms), $urandom_range(MaxTerms + 2, 14));
        end else begin
          repeat ($urandom_range(4, 1)) begin
            send_item(spsub_op_e'($urandom_range(3)), $urandom, ExpW'($urandom_range(1023)));
          end
        end
      end
      if (phase == 0) begin
        pause_until_drained();
      end
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (pending != 0) begin
      $display("%0d predicted results never came out", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
